/* sv/ppec_pkg.sv */
// Package for the pipeline performance event counter.
// Holds field widths, table depth, register indexes and the jump search types.
// No dependencies; every other file imports it.
package ppec_pkg;

  localparam int JUMP_TABLE_DEPTH = 128;
  localparam int FILL_W = $clog2(JUMP_TABLE_DEPTH + 1);

  localparam int WORD_W = 32;
  localparam int TIME_W = 48;
  localparam int ELAPSED_W = 45;
  localparam int MASK_W = 8;
  localparam int KIND_W = 4;
  localparam int COUNT_W = 32;
  localparam int DISTINCT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam int TIME_DIV = 10;
  localparam int REM_W = $clog2(TIME_DIV);
  localparam int DIV_BITS = 8;
  localparam int DIV_STEPS = TIME_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLUSH_MASK  = 2'd0,
    CFG_LOAD_MASK   = 2'd1,
    CFG_FIRST_MASK  = 2'd2,
    CFG_SECOND_MASK = 2'd3
  } cfg_idx_t;

  localparam logic [MASK_W-1:0] FLUSH_MASK_RST  = 8'd1;
  localparam logic [MASK_W-1:0] LOAD_MASK_RST   = 8'd1;
  localparam logic [MASK_W-1:0] FIRST_MASK_RST  = 8'd2;
  localparam logic [MASK_W-1:0] SECOND_MASK_RST = 8'd4;

  localparam logic [KIND_W-1:0] JK_NONE = 4'd0;
  localparam logic [KIND_W-1:0] JK_NEXT = 4'd1;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] key;
  } ppec_tok_t;

  typedef struct packed {
    logic stop;
    logic ins;
  } ppec_evt_t;

  typedef struct packed {
    logic done;
    logic inserted;
  } ppec_stat_t;

endpackage

/* sv/ppec_if.sv */
// Request channels of the pipeline performance event counter.
// Input snapshot channel and result channel, each with valid and ready.
// Depends on ppec_pkg for the field widths.
interface ppec_in_if;
  import ppec_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] retire_word0;
  logic [WORD_W-1:0] retire_word1;
  logic [TIME_W-1:0] cycle_time;
  logic [MASK_W-1:0] flush_bits;
  logic [MASK_W-1:0] stall_bits0;
  logic [MASK_W-1:0] stall_bits1;
  logic              steer_block;
  logic [KIND_W-1:0] jump_kind;
  logic [WORD_W-1:0] jump_address;

  modport source (
    output valid, retire_word0, retire_word1, cycle_time, flush_bits, stall_bits0,
    output stall_bits1, steer_block, jump_kind, jump_address,
    input  ready
  );

  modport sink (
    input  valid, retire_word0, retire_word1, cycle_time, flush_bits, stall_bits0,
    input  stall_bits1, steer_block, jump_kind, jump_address,
    output ready
  );
endinterface

interface ppec_out_if;
  import ppec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_W-1:0]    retired_count;
  logic [COUNT_W-1:0]    flushes;
  logic [COUNT_W-1:0]    load_stalls;
  logic [COUNT_W-1:0]    split_stalls;
  logic [COUNT_W-1:0]    steer_stalls;
  logic [COUNT_W-1:0]    jumps_seen;
  logic [DISTINCT_W-1:0] distinct_jumps;
  logic [ELAPSED_W-1:0]  elapsed_time;

  modport source (
    output valid, retired_count, flushes, load_stalls, split_stalls, steer_stalls,
    output jumps_seen, distinct_jumps, elapsed_time,
    input  ready
  );

  modport sink (
    input  valid, retired_count, flushes, load_stalls, split_stalls, steer_stalls,
    input  jumps_seen, distinct_jumps, elapsed_time,
    output ready
  );
endinterface

/* sv/ppec_cell.sv */
// One cell of the jump address chain: holds one table entry and its valid mark.
// Takes the search token from its left neighbor and passes it on through a register when it does not stop here.
// Depends on ppec_pkg.
module ppec_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ppec_pkg::ppec_tok_t tok_i,
  output ppec_pkg::ppec_tok_t tok_o,
  output ppec_pkg::ppec_evt_t evt_o
);
  import ppec_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] entry_r, entry_nxt;
  logic              tok_vld_r, tok_vld_nxt;
  logic [WORD_W-1:0] tok_key_r;
  logic              match;
  logic              ins;
  logic              stop;

  always_comb begin
    match       = valid_r && (entry_r == tok_i.key);
    ins         = tok_i.vld && !valid_r;
    stop        = tok_i.vld && (match || !valid_r);
    tok_vld_nxt = tok_i.vld && valid_r && !match;
    valid_nxt   = valid_r || ins;
    entry_nxt   = ins ? tok_i.key : entry_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_vld_r <= tok_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r   <= entry_nxt;
    tok_key_r <= tok_i.key;
  end

  assign tok_o.vld  = tok_vld_r;
  assign tok_o.key  = tok_key_r;
  assign evt_o.stop = stop;
  assign evt_o.ins  = ins;

endmodule

/* sv/ppec_jchain.sv */
// Chain of jump table cells; valid entries always form a prefix of the chain.
// The token stops at a matching cell or claims the first empty one.
// Depends on ppec_pkg and ppec_cell.
module ppec_jchain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppec_pkg::ppec_tok_t  tok_i,
  output ppec_pkg::ppec_stat_t stat_o
);
  import ppec_pkg::*;

  ppec_tok_t                   link [0:JUMP_TABLE_DEPTH];
  logic [JUMP_TABLE_DEPTH-1:0] stop_vec;
  logic [JUMP_TABLE_DEPTH-1:0] ins_vec;
  logic [JUMP_TABLE_DEPTH-1:0] tok_vld_vec;
  ppec_stat_t                  stat_r, stat_nxt;

  assign link[0] = tok_i;

  for (genvar i = 0; i < JUMP_TABLE_DEPTH; i++) begin : g_cell
    ppec_evt_t evt;

    ppec_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (link[i]),
      .tok_o (link[i+1]),
      .evt_o (evt)
    );

    assign stop_vec[i]    = evt.stop;
    assign ins_vec[i]     = evt.ins;
    assign tok_vld_vec[i] = link[i+1].vld;
  end

  // A token leaving the last cell means the table was full and held no match.
  always_comb begin
    stat_nxt.done     = (|stop_vec) || tok_vld_vec[JUMP_TABLE_DEPTH-1];
    stat_nxt.inserted = |ins_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r <= stat_nxt;
    end
  end

  assign stat_o = stat_r;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one search token in the jump chain");

  a_empty_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    tok_i.vld |-> (tok_vld_vec == '0))
    else $error("new search started while a token is still in the chain");

  a_single_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stop_vec))
    else $error("several cells stopped the same token");

  a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat_r.inserted |-> stat_r.done)
    else $error("insert reported without search completion");
`endif

endmodule

/* sv/ppec_div10.sv */
// Divider of the elapsed time by ten, eight quotient bits per cycle.
// Restoring long division with a four-bit remainder.
// Depends on ppec_pkg.
module ppec_div10 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ppec_pkg::TIME_W-1:0]    dividend,
  output logic                           busy,
  output logic [ppec_pkg::ELAPSED_W-1:0] quotient
);
  import ppec_pkg::*;

  logic [TIME_W-1:0]    q_r, q_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    q_step;
  logic [REM_W-1:0]     rem_step;
  logic [REM_W:0]       part;

  always_comb begin
    q_step   = q_r;
    rem_step = rem_r;
    part     = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      part   = {rem_step, q_step[TIME_W-1]};
      q_step = {q_step[TIME_W-2:0], 1'b0};
      if (part >= (REM_W+1)'(TIME_DIV)) begin
        rem_step  = REM_W'(part - (REM_W+1)'(TIME_DIV));
        q_step[0] = 1'b1;
      end else begin
        rem_step = part[REM_W-1:0];
      end
    end

    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r[ELAPSED_W-1:0];

endmodule

/* sv/pipeline_perf_event_counter_core.sv */
// Top level of the pipeline performance event counter.
// Depends on ppec_pkg, ppec_if, ppec_jchain and ppec_div10.
//
//   channel   direction  handshake          carries
//   in_chan   sink       valid / ready      one pipeline snapshot per request
//   out_chan  source     valid / ready      all counters, jump count, run time
//   cfg_*     sink       cfg_we only        four 8-bit event masks
//
// One request is in work at a time; its result waits for the divide-by-ten unit and, for a jump,
// also for the chain search that finds its address in, or writes it to, a chain cell.
// The divide-by-ten unit works in six 8-bit steps.
// The jump search walks one cell per cycle; a miss on a full table ends past the last cell.
// A result waiting on out_chan does not hold off the next request.
// rst_n is synchronous and clears all counters and valid marks.
module pipeline_perf_event_counter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  ppec_in_if.sink                        in_chan,
  ppec_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [ppec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppec_pkg::MASK_W-1:0]    cfg_data
);
  import ppec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } ppec_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    retired_count;
    logic [COUNT_W-1:0]    flushes;
    logic [COUNT_W-1:0]    load_stalls;
    logic [COUNT_W-1:0]    split_stalls;
    logic [COUNT_W-1:0]    steer_stalls;
    logic [COUNT_W-1:0]    jumps_seen;
    logic [DISTINCT_W-1:0] distinct_jumps;
    logic [ELAPSED_W-1:0]  elapsed_time;
  } ppec_res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic covers(input logic [MASK_W-1:0] bits,
                                  input logic [MASK_W-1:0] mask);
    return (bits & mask) == mask;
  endfunction

  function automatic logic [DISTINCT_W-1:0] fill_count(input logic [FILL_W-1:0] f);
    logic [FILL_W+DISTINCT_W-1:0] wide;
    wide = {{DISTINCT_W{1'b0}}, f};
    if (wide > (FILL_W+DISTINCT_W)'(255)) begin
      return '1;
    end
    return wide[DISTINCT_W-1:0];
  endfunction

  ppec_state_t         state_r, state_nxt;
  logic [MASK_W-1:0]   flush_mask_r, load_mask_r, first_mask_r, second_mask_r;
  logic [TIME_W-1:0]   first_r, first_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic                started_r, started_nxt;
  logic [COUNT_W-1:0]  retire_r, retire_nxt;
  logic [COUNT_W-1:0]  flush_r, flush_nxt;
  logic [COUNT_W-1:0]  load_r, load_nxt;
  logic [COUNT_W-1:0]  split_r, split_nxt;
  logic [COUNT_W-1:0]  steer_r, steer_nxt;
  logic [COUNT_W-1:0]  jump_r, jump_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                srch_pend_r, srch_pend_nxt;
  logic                start_r;
  logic [WORD_W-1:0]   key_r;
  logic                out_valid_r, out_valid_nxt;
  ppec_res_t           res_r;

  logic                in_acc;
  logic                is_jump;
  logic                retired;
  logic [1:0]          retire_inc;
  logic [COUNT_W:0]    retire_sum;
  logic                load_hit;
  logic                split_hit;
  logic [TIME_W-1:0]   diff;
  logic                out_load;
  ppec_tok_t           chain_tok;
  ppec_stat_t          chain_stat;
  logic                div_busy;
  logic [ELAPSED_W-1:0] div_q;

  assign in_chan.ready = rst_n && (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    is_jump    = !(in_chan.jump_kind inside {JK_NONE, JK_NEXT});
    retire_inc = {1'b0, in_chan.retire_word0 != '0} + {1'b0, in_chan.retire_word1 != '0};
    retired    = (retire_inc != 2'd0);
    retire_sum = {1'b0, retire_r} + (COUNT_W+1)'(retire_inc);
    load_hit   = covers(in_chan.stall_bits0, load_mask_r) &&
                 covers(in_chan.stall_bits1, load_mask_r);
    split_hit  = (covers(in_chan.stall_bits0, second_mask_r) &&
                  covers(in_chan.stall_bits1, first_mask_r)) ||
                 (covers(in_chan.stall_bits1, second_mask_r) &&
                  covers(in_chan.stall_bits0, first_mask_r));

    first_nxt   = first_r;
    last_nxt    = last_r;
    started_nxt = started_r;
    retire_nxt  = retire_r;
    flush_nxt   = flush_r;
    load_nxt    = load_r;
    split_nxt   = split_r;
    steer_nxt   = steer_r;
    jump_nxt    = jump_r;

    if (in_acc) begin
      retire_nxt = retire_sum[COUNT_W] ? '1 : retire_sum[COUNT_W-1:0];
      if (retired) begin
        last_nxt = in_chan.cycle_time;
      end
      if (covers(in_chan.flush_bits, flush_mask_r)) begin
        flush_nxt = sat_inc(flush_r);
      end
      if (load_hit) begin
        load_nxt = sat_inc(load_r);
      end else if (split_hit) begin
        split_nxt = sat_inc(split_r);
      end else if (in_chan.steer_block) begin
        steer_nxt = sat_inc(steer_r);
      end
      if (is_jump) begin
        jump_nxt = sat_inc(jump_r);
      end
      if (!started_r) begin
        first_nxt = in_chan.cycle_time;
      end
      started_nxt = 1'b1;
    end

    diff = (last_nxt >= first_nxt) ? (last_nxt - first_nxt) : '0;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (chain_stat.inserted) begin
      fill_nxt = fill_r + 1'b1;
    end

    srch_pend_nxt = srch_pend_r;
    if (in_acc && is_jump) begin
      srch_pend_nxt = 1'b1;
    end else if (chain_stat.done) begin
      srch_pend_nxt = 1'b0;
    end

    out_load = (state_r == ST_BUSY) && !srch_pend_r && !div_busy &&
               (!out_valid_r || out_chan.ready);

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      flush_mask_r  <= FLUSH_MASK_RST;
      load_mask_r   <= LOAD_MASK_RST;
      first_mask_r  <= FIRST_MASK_RST;
      second_mask_r <= SECOND_MASK_RST;
      first_r       <= '0;
      last_r        <= '0;
      started_r     <= 1'b0;
      retire_r      <= '0;
      flush_r       <= '0;
      load_r        <= '0;
      split_r       <= '0;
      steer_r       <= '0;
      jump_r        <= '0;
      fill_r        <= '0;
      srch_pend_r   <= 1'b0;
      start_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      started_r   <= started_nxt;
      retire_r    <= retire_nxt;
      flush_r     <= flush_nxt;
      load_r      <= load_nxt;
      split_r     <= split_nxt;
      steer_r     <= steer_nxt;
      jump_r      <= jump_nxt;
      fill_r      <= fill_nxt;
      srch_pend_r <= srch_pend_nxt;
      start_r     <= in_acc && is_jump;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLUSH_MASK:  flush_mask_r  <= cfg_data;
          CFG_LOAD_MASK:   load_mask_r   <= cfg_data;
          CFG_FIRST_MASK:  first_mask_r  <= cfg_data;
          CFG_SECOND_MASK: second_mask_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_chan.jump_address;
    end
    if (out_load) begin
      res_r.retired_count  <= retire_r;
      res_r.flushes        <= flush_r;
      res_r.load_stalls    <= load_r;
      res_r.split_stalls   <= split_r;
      res_r.steer_stalls   <= steer_r;
      res_r.jumps_seen     <= jump_r;
      res_r.distinct_jumps <= fill_count(fill_r);
      res_r.elapsed_time   <= div_q;
    end
  end

  assign chain_tok.vld = start_r;
  assign chain_tok.key = key_r;

  ppec_jchain u_jchain (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok_i  (chain_tok),
    .stat_o (chain_stat)
  );

  ppec_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (diff),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_chan.valid          = out_valid_r;
  assign out_chan.retired_count  = res_r.retired_count;
  assign out_chan.flushes        = res_r.flushes;
  assign out_chan.load_stalls    = res_r.load_stalls;
  assign out_chan.split_stalls   = res_r.split_stalls;
  assign out_chan.steer_stalls   = res_r.steer_stalls;
  assign out_chan.jumps_seen     = res_r.jumps_seen;
  assign out_chan.distinct_jumps = res_r.distinct_jumps;
  assign out_chan.elapsed_time   = res_r.elapsed_time;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(JUMP_TABLE_DEPTH))
    else $error("jump table fill count beyond table depth");

  a_done_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    chain_stat.done |-> (state_r == ST_BUSY) && srch_pend_r)
    else $error("jump search finished with no search pending");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_BUSY) && !$past(div_busy))
    else $error("result loaded outside a finished request");
`endif

endmodule
